>>> rtl/bft_pkg.sv
// Package for the three-hash Bloom filter: constants, sequencer states and
// the structs passed between its modules. Used by every file in rtl/.
package bft_pkg;

    localparam int MAX_FILTER_BITS = 65536;
    localparam int IDX_W = $clog2(MAX_FILTER_BITS);
    localparam int SIZE_W = IDX_W + 1;
    localparam int ROW_BITS = 32;
    localparam int BIT_W = $clog2(ROW_BITS);
    localparam int ROW_AW = IDX_W - BIT_W;
    localparam int HASH_W = 32;
    localparam int CNT_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_INIT = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] DJB_INIT = 32'd5381;
    localparam logic [HASH_W-1:0] SAX_INIT = 32'd0;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd1000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 17'd65536;
    localparam logic [2:0] MASK_RESET = 3'd7;

    localparam logic CFG_FILTER_SIZE = 1'b0;
    localparam logic CFG_HASH_MASK = 1'b1;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [1:0] HSEL_SAX = 2'd0;
    localparam logic [1:0] HSEL_FNV = 2'd1;
    localparam logic [1:0] HSEL_DJB = 2'd2;
    localparam logic [1:0] HSEL_END = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEL,
        ST_MOD,
        ST_READ,
        ST_USE,
        ST_DONE
    } state_t;

    // The first member is the most significant bit, so SAX sits in bit 0.
    typedef struct packed {
        logic djb_en;
        logic fnv_en;
        logic sax_en;
    } hash_mask_t;

    typedef struct packed {
        logic [HASH_W-1:0] sax;
        logic [HASH_W-1:0] fnv;
        logic [HASH_W-1:0] djb;
    } hash_vals_t;

    typedef struct packed {
        logic done;
        logic [IDX_W-1:0] rem;
    } mod_stat_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic [ROW_AW-1:0] addr;
        logic [ROW_BITS-1:0] wdata;
    } store_req_t;

endpackage

>>> rtl/bft_hash.sv
// Running SAX, FNV-1 and djb2 hash accumulators, updated one key byte per
// cycle while step is high. Depends on bft_pkg.
module bft_hash
    import bft_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            clear,
    input  logic [7:0]      key_byte,
    output hash_vals_t      hashes
);

    logic [HASH_W-1:0] sax_reg, sax_next;
    logic [HASH_W-1:0] fnv_reg, fnv_next;
    logic [HASH_W-1:0] djb_reg, djb_next;
    logic [HASH_W-1:0] byte_z;
    logic [HASH_W-1:0] byte_s;
    logic [2*HASH_W-1:0] fnv_prod;

    assign byte_z = {24'd0, key_byte};
    assign byte_s = {{24{key_byte[7]}}, key_byte};
    assign fnv_prod = {32'd0, fnv_reg} * {32'd0, FNV_PRIME};

    always_comb
    begin
        sax_next = sax_reg;
        fnv_next = fnv_reg;
        djb_next = djb_reg;
        if (clear)
        begin
            sax_next = SAX_INIT;
            fnv_next = FNV_INIT;
            djb_next = DJB_INIT;
        end
        else if (step)
        begin
            sax_next = sax_reg ^ ((sax_reg << 5) + (sax_reg >> 2) + byte_z);
            fnv_next = fnv_prod[HASH_W-1:0] ^ byte_z;
            djb_next = (djb_reg << 5) + djb_reg + byte_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sax_reg <= SAX_INIT;
            fnv_reg <= FNV_INIT;
            djb_reg <= DJB_INIT;
        end
        else
        begin
            sax_reg <= sax_next;
            fnv_reg <= fnv_next;
            djb_reg <= djb_next;
        end
    end

    assign hashes.sax = sax_reg;
    assign hashes.fnv = fnv_reg;
    assign hashes.djb = djb_reg;

endmodule

>>> rtl/bft_mod.sv
// Shared remainder unit: reduces a 32-bit hash modulo the filter size, one
// dividend bit per cycle. Depends on bft_pkg.
module bft_mod
    import bft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output mod_stat_t         stat
);

    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SIZE_W-1:0] trial;
    logic [SIZE_W-1:0] diff;

    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff = trial - divisor;

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            if (trial >= divisor)
                rem_next = diff[IDX_W-1:0];
            else
                rem_next = trial[IDX_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.rem = rem_reg;

endmodule

>>> rtl/bft_store.sv
// Filter bit store: 2048 rows of 32 bits, one port, registered read data.
// Depends on bft_pkg.
module bft_store
    import bft_pkg::*;
(
    input  logic                clk,
    input  store_req_t          req,
    output logic [ROW_BITS-1:0] rdata
);

    logic [ROW_BITS-1:0] mem [0:(1 << ROW_AW)-1];
    logic [ROW_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.addr] <= req.wdata;
        if (req.rd_en)
            rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bloom_filter_three_hash.sv
// Top level of the three-hash Bloom filter: sequencer, configuration
// registers and result register. Depends on bft_pkg, bft_hash, bft_mod and
// bft_store.
//
// Keys arrive on the s_ channel one byte per transfer, with tlast on the
// final byte and tuser giving the operation (0 add, 1 check). A final byte
// starts a pass over the enabled hashes: each is reduced by the shared
// remainder unit, which retires one dividend bit per cycle, and is then
// used in a read-modify-write of the single-port bit store. s_tready is
// low while a final byte is in work. Each key yields one transfer on the
// m_ channel: tdata bit 0 is present, tuser is set for an add. The result
// waits in an output register, so body bytes of the next key are taken
// while m_tready is low; a finished key holds the sequencer until the
// register is free. After reset the bit store is cleared one row per
// cycle, with s_tready low; configuration writes on cfg_we are taken at
// any time.
module bloom_filter_three_hash
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // present, then zero fill
    output logic        m_tuser,   // from_add
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    hash_mask_t        mask_reg;
    logic [1:0]        hsel_reg, hsel_next;
    logic              kind_reg, kind_next;
    logic              present_reg, present_next;
    logic [ROW_AW-1:0] clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_present_reg, m_present_next;
    logic              m_add_reg, m_add_next;

    logic              in_xfer;
    logic              hash_step;
    logic              hash_clear;
    logic              mod_start;
    logic [HASH_W-1:0] mod_dvd;
    logic [SIZE_W-1:0] eff_size;
    logic              hash_on;
    logic              out_free;
    hash_vals_t        hashes;
    mod_stat_t         mstat;
    store_req_t        sreq;
    logic [ROW_BITS-1:0] rdata;
    logic [ROW_BITS-1:0] bit_sel;

    bft_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (hash_step),
        .clear    (hash_clear),
        .key_byte (s_tdata),
        .hashes   (hashes)
    );

    bft_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (eff_size),
        .stat     (mstat)
    );

    bft_store u_store (
        .clk   (clk),
        .req   (sreq),
        .rdata (rdata)
    );

    always_comb
    begin
        eff_size = size_reg;
        if (size_reg == '0)
            eff_size = SIZE_W'(1);
        else if (size_reg > SIZE_MAX)
            eff_size = SIZE_MAX;
    end

    always_comb
    begin
        case (hsel_reg)
            HSEL_SAX: hash_on = mask_reg.sax_en;
            HSEL_FNV: hash_on = mask_reg.fnv_en;
            HSEL_DJB: hash_on = mask_reg.djb_en;
            default:  hash_on = 1'b0;
        endcase
    end

    always_comb
    begin
        case (hsel_reg)
            HSEL_SAX: mod_dvd = hashes.sax;
            HSEL_FNV: mod_dvd = hashes.fnv;
            default:  mod_dvd = hashes.djb;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;
    assign in_xfer = s_tvalid && s_tready;
    assign bit_sel = ROW_BITS'(1) << mstat.rem[BIT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tlast)
                    state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (hsel_reg == HSEL_END)
                    state_next = ST_DONE;
                else if (hash_on)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mstat.done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_USE;
            end
            ST_USE:
            begin
                state_next = ST_SEL;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        hash_step = 1'b0;
        hash_clear = 1'b0;
        mod_start = 1'b0;
        sreq = '0;
        hsel_next = hsel_reg;
        kind_next = kind_reg;
        present_next = present_reg;
        clr_next = clr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_present_next = m_present_reg;
        m_add_next = m_add_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                sreq.wr_en = 1'b1;
                sreq.addr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                hash_step = in_xfer;
                if (in_xfer && s_tlast)
                begin
                    kind_next = s_tuser;
                    present_next = 1'b1;
                    hsel_next = HSEL_SAX;
                end
            end
            ST_SEL:
            begin
                if (hsel_reg != HSEL_END)
                begin
                    if (hash_on)
                        mod_start = 1'b1;
                    else
                        hsel_next = hsel_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                sreq.rd_en = 1'b1;
                sreq.addr = mstat.rem[IDX_W-1:BIT_W];
            end
            ST_USE:
            begin
                sreq.addr = mstat.rem[IDX_W-1:BIT_W];
                sreq.wdata = rdata | bit_sel;
                if (kind_reg == KIND_ADD)
                    sreq.wr_en = 1'b1;
                else if ((rdata & bit_sel) == '0)
                    present_next = 1'b0;
                hsel_next = hsel_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    hash_clear = 1'b1;
                    m_valid_next = 1'b1;
                    m_add_next = (kind_reg == KIND_ADD);
                    m_present_next = (kind_reg == KIND_CHECK) && present_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            hsel_reg <= HSEL_SAX;
            kind_reg <= KIND_ADD;
            present_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            size_reg <= SIZE_RESET;
            mask_reg <= MASK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            hsel_reg <= hsel_next;
            kind_reg <= kind_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_SIZE: size_reg <= cfg_data;
                    CFG_HASH_MASK:   mask_reg <= cfg_data[2:0];
                    default:         size_reg <= size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_present_reg <= m_present_next;
        m_add_reg <= m_add_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_present_reg};
    assign m_tuser = m_add_reg;

endmodule

>>> tb/bloom_filter_three_hash_test.sv
// Self-checking testbench for bloom_filter_three_hash: keys go in one byte per transfer,
// and each membership result is checked against a predictor of the three hashes and bit store.
// Depends on bft_pkg and the RTL of bloom_filter_three_hash.

typedef struct packed {
    logic [7:0] data;
    logic       from_add;
} key_result_t;

class membership_scoreboard;
    bit          filter_bits [bft_pkg::MAX_FILTER_BITS];
    bit [31:0]   sax_h;
    bit [31:0]   fnv_h;
    bit [31:0]   djb_h;
    bit [16:0]   size_reg;
    bit [2:0]    mask_reg;
    key_result_t pending_results [$];
    int          errors;

    function new();
        size_reg = bft_pkg::SIZE_RESET;
        mask_reg = bft_pkg::MASK_RESET;
        errors = 0;
        restart_hashes();
    endfunction

    function void restart_hashes();
        sax_h = bft_pkg::SAX_INIT;
        fnv_h = bft_pkg::FNV_INIT;
        djb_h = bft_pkg::DJB_INIT;
    endfunction

    function void write_reg(logic index, logic [16:0] value);
        if (index == bft_pkg::CFG_FILTER_SIZE)
            size_reg = value;
        else
            mask_reg = value[2:0];
    endfunction

    function void take_byte(logic kind, logic [7:0] b, logic last);
        bit [31:0]   modulus;
        bit [31:0]   hash;
        bit [31:0]   slot;
        bit          hit;
        key_result_t res;
        hit = 1'b1;
        sax_h = sax_h ^ ((sax_h << 5) + (sax_h >> 2) + {24'd0, b});
        fnv_h = (fnv_h * bft_pkg::FNV_PRIME) ^ {24'd0, b};
        djb_h = djb_h * 32'd33 + {{24{b[7]}}, b};
        if (!last)
            return;
        if (size_reg == 17'd0)
            modulus = 32'd1;
        else if (size_reg > bft_pkg::SIZE_MAX)
            modulus = {15'd0, bft_pkg::SIZE_MAX};
        else
            modulus = {15'd0, size_reg};
        for (int k = 0; k < 3; k++)
        begin
            if (!mask_reg[k])
                continue;
            hash = (k == 0) ? sax_h : (k == 1) ? fnv_h : djb_h;
            slot = hash % modulus;
            if (kind == bft_pkg::KIND_ADD)
                filter_bits[slot[15:0]] = 1'b1;
            else if (!filter_bits[slot[15:0]])
                hit = 1'b0;
        end
        restart_hashes();
        res.data = {7'd0, (kind == bft_pkg::KIND_CHECK) && hit};
        res.from_add = (kind == bft_pkg::KIND_ADD);
        pending_results.push_back(res);
    endfunction

    function void report(string field, int want, int got);
        errors++;
        if (errors <= 10)
            $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void match_result(logic [7:0] data, logic from_add);
        key_result_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected result transfer", 0, 1);
            return;
        end
        want = pending_results.pop_front();
        if (data !== want.data)
            report("present", want.data, data);
        if (from_add !== want.from_add)
            report("from_add", want.from_add, from_add);
    endfunction
endclass

module bloom_filter_three_hash_test;
    import bft_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_BYTES = 120;
    localparam int POOL_DEPTH = 48;
    localparam int KEY_MAX = 32;
    localparam int NUM_PHASES = 12;

    typedef struct {
        logic [7:0] bytes [KEY_MAX];
        int         len;
    } key_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;

    membership_scoreboard sb;
    int   gap_pct;
    int   stall_pct;
    key_t added_keys [$];

    logic [16:0] phase_size [NUM_PHASES] = '{17'd16, 17'd0, 17'd1, 17'd65536, 17'd131071,
        17'd70000, 17'd997, 17'd4096, 17'd2, 17'd50000, 17'd300, 17'd1000};
    logic [2:0]  phase_mask [NUM_PHASES] = '{3'd7, 3'd7, 3'd5, 3'd7, 3'd7,
        3'd3, 3'd6, 3'd1, 3'd2, 3'd4, 3'd0, 3'd7};

    bloom_filter_three_hash u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("bloom_filter_three_hash_test: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic put_byte(logic kind, logic [7:0] b, logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= kind;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.take_byte(kind, b, last);
    endtask

    // Only the kind on the final byte counts; flip_body puts the other kind on earlier bytes.
    task automatic put_key(key_t k, logic kind, logic flip_body);
        for (int i = 0; i < k.len; i++)
            put_byte((i == k.len - 1) ? kind : kind ^ flip_body, k.bytes[i], i == k.len - 1);
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic configure(logic [16:0] size, logic [2:0] mask);
        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FILTER_SIZE;
        cfg_data <= size;
        sb.write_reg(CFG_FILTER_SIZE, size);
        @(posedge clk);
        cfg_index <= CFG_HASH_MASK;
        cfg_data <= {14'd0, mask};
        sb.write_reg(CFG_HASH_MASK, {14'd0, mask});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 58; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 58; end
            default: begin gap_pct = 35; stall_pct = 35; end
        endcase
    endtask

    function automatic key_t key_of(int len, logic [23:0] packed_bytes);
        key_t k;
        k.len = len;
        for (int i = 0; i < KEY_MAX; i++)
            k.bytes[i] = (i < 3) ? packed_bytes[8*i +: 8] : 8'd0;
        return k;
    endfunction

    function automatic key_t random_key();
        key_t k;
        int   r;
        logic [7:0] corner [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        r = $urandom_range(99);
        if (r < 70)
            k.len = $urandom_range(4, 1);
        else if (r < 95)
            k.len = $urandom_range(12, 5);
        else
            k.len = $urandom_range(KEY_MAX, 13);
        for (int i = 0; i < KEY_MAX; i++)
            k.bytes[i] = ($urandom_range(9) == 0) ? corner[$urandom_range(3)]
                                                  : 8'($urandom_range(255));
        return k;
    endfunction

    initial
    begin
        int   phase_bytes;
        int   keys;
        int   pick;
        key_t k;
        sb = new();
        gap_pct = 0;
        stall_pct = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'd0;
        s_tlast <= 1'b0;
        s_tuser <= KIND_ADD;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FILTER_SIZE;
        cfg_data <= 17'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        put_key(key_of(1, 24'h000000), KIND_ADD, 1'b0);
        put_key(key_of(1, 24'h0000FF), KIND_ADD, 1'b0);
        put_key(key_of(1, 24'h000080), KIND_ADD, 1'b0);
        put_key(key_of(1, 24'h00007F), KIND_CHECK, 1'b0);
        put_key(key_of(1, 24'h000000), KIND_CHECK, 1'b0);
        put_key(key_of(1, 24'h000080), KIND_CHECK, 1'b0);
        put_key(key_of(3, 24'h0080FF), KIND_ADD, 1'b1);
        put_key(key_of(3, 24'h0080FF), KIND_CHECK, 1'b1);
        put_key(key_of(2, 24'h00AA55), KIND_CHECK, 1'b0);
        // With no hash enabled an add leaves the store alone and a check always hits.
        configure(17'd1000, 3'd0);
        put_key(key_of(2, 24'h003412), KIND_ADD, 1'b0);
        put_key(key_of(1, 24'h0000C3), KIND_CHECK, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            configure(phase_size[p], phase_mask[p]);
            phase_bytes = 0;
            keys = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                set_idling((p + keys / 8) % 4);
                if (keys == 6)
                    hold_off();
                pick = $urandom_range(99);
                if (pick < 45 || added_keys.size() == 0)
                begin
                    k = random_key();
                    put_key(k, KIND_ADD, 1'($urandom_range(1)));
                    added_keys.push_back(k);
                    if (added_keys.size() > POOL_DEPTH)
                        void'(added_keys.pop_front());
                end
                else if (pick < 75)
                begin
                    k = added_keys[$urandom_range(added_keys.size() - 1)];
                    put_key(k, KIND_CHECK, 1'($urandom_range(1)));
                end
                else
                begin
                    k = random_key();
                    put_key(k, KIND_CHECK, 1'($urandom_range(1)));
                end
                phase_bytes += k.len;
                keys++;
            end
        end

        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("bloom_filter_three_hash_test: clean");
        else
            $display("bloom_filter_three_hash_test: errors");
        $finish;
    end
endmodule
